FILE: src/interval_table_binary_search_core_assert.svh
// Assertion macros for the checker file of the interval table core.
`ifndef INTERVAL_TABLE_BINARY_SEARCH_CORE_ASSERT_SVH
`define INTERVAL_TABLE_BINARY_SEARCH_CORE_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define ITBS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must never be seen outside reset.
`define ITBS_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   `ITBS_ASSERT(lbl, clk, rst, !(cond), msg)

`endif

FILE: src/itbs_pkg.sv
package itbs_pkg;

   localparam int TABLE_ENTRIES = 256;
   localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
   localparam int KEY_W   = 56;
   localparam int COUNT_W = 9;
   localparam int SLOT_W  = 8;
   localparam int MATCH_W = 8;

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   typedef enum logic [2:0] {
      STEP_IDLE,
      STEP_DISPATCH,
      STEP_INIT,
      STEP_FIRST,
      STEP_COMPARE,
      STEP_DONE,
      STEP_LOAD
   } step_type;

   typedef enum logic [2:0] {
      OP_ACCEPT,
      OP_NONE,
      OP_INIT,
      OP_READ_MID,
      OP_COMPARE,
      OP_RESULT,
      OP_WRITE
   } op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_NOT_ACCEPTED,
      COND_IS_LOAD,
      COND_EMPTY,
      COND_GOES_ON,
      COND_OUT_BUSY
   } cond_type;

   // One control word: datapath operation, jump condition, jump target and
   // the step taken when the condition is false.
   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type jump;
      step_type next;
   } ctrl_type;

   // The microprogram.
   function automatic ctrl_type ucode(input step_type step);
      ctrl_type word;
      unique case (step)
         STEP_IDLE:     word = '{OP_ACCEPT,   COND_NOT_ACCEPTED, STEP_IDLE,    STEP_DISPATCH};
         STEP_DISPATCH: word = '{OP_NONE,     COND_IS_LOAD,      STEP_LOAD,    STEP_INIT};
         STEP_INIT:     word = '{OP_INIT,     COND_NEVER,        STEP_IDLE,    STEP_FIRST};
         STEP_FIRST:    word = '{OP_READ_MID, COND_EMPTY,        STEP_DONE,    STEP_COMPARE};
         STEP_COMPARE:  word = '{OP_COMPARE,  COND_GOES_ON,      STEP_COMPARE, STEP_DONE};
         STEP_DONE:     word = '{OP_RESULT,   COND_OUT_BUSY,     STEP_DONE,    STEP_IDLE};
         STEP_LOAD:     word = '{OP_WRITE,    COND_NEVER,        STEP_IDLE,    STEP_DONE};
         default:       word = '{OP_NONE,     COND_NEVER,        STEP_IDLE,    STEP_IDLE};
      endcase
      return word;
   endfunction

endpackage

FILE: src/itbs_ram.sv
module itbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/interval_table_binary_search_core.sv
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   command, entry_index, range_start, range_end, query_key
// rsp      out        rsp_valid/rsp_stall   found, match_index
// csr      in         csr_write_en          entry_count (write only)
//
// A load passes the sequencer through the accept, dispatch, load and done steps, a lookup
// through accept, dispatch, init, first, one compare per probe (none for an empty table, at
// most 9 for 256 entries) and done; the result is registered as the step leaves done.
// One item is in work at a time; a finished result waits in the output register while the
// next item is accepted, and the input stalls until the sequencer is idle. Reset is
// synchronous and clears the sequencer, rsp_valid and entry_count; the table is undefined.

module interval_table_binary_search_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_command,
   input  logic [itbs_pkg::SLOT_W-1:0]   req_entry_index,
   input  logic [itbs_pkg::KEY_W-1:0]    req_range_start,
   input  logic [itbs_pkg::KEY_W-1:0]    req_range_end,
   input  logic [itbs_pkg::KEY_W-1:0]    req_query_key,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_found,
   output logic [itbs_pkg::MATCH_W-1:0]  rsp_match_index,
   input  logic                          csr_write_en,
   input  logic [itbs_pkg::COUNT_W-1:0]  csr_write_data
);

   import itbs_pkg::*;

   // Sequencer state and the current control word.
   step_type step_ff, step_in;
   ctrl_type ctrl;
   logic     cond_true;

   // Latched item.
   logic               cmd_ff,   cmd_in;
   logic [SLOT_W-1:0]  slot_ff,  slot_in;
   logic [KEY_W-1:0]   start_ff, start_in;
   logic [KEY_W-1:0]   end_ff,   end_in;
   logic [KEY_W-1:0]   key_ff,   key_in;

   // Search window: low is inclusive, high is exclusive.
   logic [CNT_W-1:0]   low_ff,  low_in;
   logic [CNT_W-1:0]   high_ff, high_in;
   logic [IDX_W-1:0]   mid_ff,  mid_in;
   logic               hit_ff,  hit_in;

   logic [COUNT_W-1:0] count_ff, count_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [MATCH_W-1:0] rsp_index_ff, rsp_index_in;

   // Datapath signals.
   logic                 req_fire;
   logic                 out_free;
   logic [CNT_W-1:0]     entries;
   logic [IDX_W-1:0]     mid_first;
   logic [IDX_W-1:0]     mid_next;
   logic [CNT_W-1:0]     low_upd;
   logic [CNT_W-1:0]     high_upd;
   logic                 is_match;
   logic                 goes_on;
   logic [KEY_W-1:0]     rd_start;
   logic [KEY_W-1:0]     rd_end;
   logic [2*KEY_W-1:0]   rd_data;
   logic [IDX_W-1:0]     rd_addr;
   logic                 wr_en;

   // Midpoint of a non-empty window, rounded down like the inclusive form.
   function automatic logic [IDX_W-1:0] mid_of(input logic [CNT_W-1:0] lo,
                                                input logic [CNT_W-1:0] hi);
      logic [CNT_W-1:0] span;
      span = hi - lo - CNT_W'(1);
      return IDX_W'(lo + (span >> 1));
   endfunction

   itbs_ram #(
      .WIDTH (2 * KEY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (IDX_W'(slot_ff)),
      .wr_data ({start_ff, end_ff}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_start = rd_data[2*KEY_W-1:KEY_W];
   assign rd_end   = rd_data[KEY_W-1:0];

   // The datapath, driven by the control word of the current step.
   always_comb begin
      ctrl     = ucode(step_ff);
      req_fire = req_valid && (ctrl.op == OP_ACCEPT);
      out_free = !rsp_valid_ff || !rsp_stall;

      // Counts beyond the table size search the whole table.
      if (32'(count_ff) > TABLE_ENTRIES) begin
         entries = CNT_W'(TABLE_ENTRIES);
      end else begin
         entries = CNT_W'(count_ff);
      end

      mid_first = mid_of(low_ff, high_ff);

      // Both ends of an interval count as inside it.
      is_match = (rd_start == key_ff) || (rd_end == key_ff) ||
                 ((key_ff > rd_start) && (key_ff < rd_end));
      low_upd  = low_ff;
      high_upd = high_ff;
      if (rd_start > key_ff) begin
         high_upd = CNT_W'(mid_ff);
      end else begin
         low_upd = CNT_W'(mid_ff) + CNT_W'(1);
      end
      goes_on  = !is_match && (low_upd < high_upd);
      mid_next = mid_of(low_upd, high_upd);

      rd_addr = (ctrl.op == OP_COMPARE) ? mid_next : mid_first;
      wr_en   = (ctrl.op == OP_WRITE) && (32'(slot_ff) < TABLE_ENTRIES);

      cmd_in   = cmd_ff;
      slot_in  = slot_ff;
      start_in = start_ff;
      end_in   = end_ff;
      key_in   = key_ff;
      low_in   = low_ff;
      high_in  = high_ff;
      mid_in   = mid_ff;
      hit_in   = hit_ff;
      count_in = csr_write_en ? csr_write_data : count_ff;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_found_in = rsp_found_ff;
      rsp_index_in = rsp_index_ff;

      unique case (ctrl.op)
         OP_ACCEPT: begin
            if (req_fire) begin
               cmd_in   = req_command;
               slot_in  = req_entry_index;
               start_in = req_range_start;
               end_in   = req_range_end;
               key_in   = req_query_key;
            end
         end
         OP_INIT: begin
            low_in  = '0;
            high_in = entries;
            hit_in  = 1'b0;
         end
         OP_READ_MID: begin
            mid_in = mid_first;
         end
         OP_COMPARE: begin
            hit_in = is_match;
            if (!is_match) begin
               low_in  = low_upd;
               high_in = high_upd;
            end
            if (goes_on) begin
               mid_in = mid_next;
            end
         end
         OP_RESULT: begin
            // The result register takes a new item as soon as the old one
            // leaves, in the same cycle.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = (cmd_ff == CMD_LOOKUP) && hit_ff;
               rsp_index_in = ((cmd_ff == CMD_LOOKUP) && hit_ff) ?
                              MATCH_W'(mid_ff) : '0;
            end
         end
         OP_NONE, OP_WRITE: begin
         end
         default: begin
         end
      endcase

      unique case (ctrl.cond)
         COND_NEVER:        cond_true = 1'b0;
         COND_NOT_ACCEPTED: cond_true = !req_fire;
         COND_IS_LOAD:      cond_true = (cmd_ff == CMD_LOAD);
         COND_EMPTY:        cond_true = (low_ff >= high_ff);
         COND_GOES_ON:      cond_true = goes_on;
         COND_OUT_BUSY:     cond_true = !out_free;
         default:           cond_true = 1'b0;
      endcase

      step_in = cond_true ? ctrl.jump : ctrl.next;
   end

   assign req_stall       = (ctrl.op != OP_ACCEPT);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_match_index = rsp_index_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      slot_ff      <= slot_in;
      start_ff     <= start_in;
      end_ff       <= end_in;
      key_ff       <= key_in;
      low_ff       <= low_in;
      high_ff      <= high_in;
      mid_ff       <= mid_in;
      hit_ff       <= hit_in;
      rsp_found_ff <= rsp_found_in;
      rsp_index_ff <= rsp_index_in;
   end

endmodule

FILE: src/itbs_checker.sv
`include "interval_table_binary_search_core_assert.svh"

module itbs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic                          rsp_found,
   input logic [itbs_pkg::MATCH_W-1:0]  rsp_match_index
);

   import itbs_pkg::*;

   // A waiting result stays offered.
   `ITBS_ASSERT(a_rsp_valid_holds, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "rsp_valid dropped while stalled")

   // A waiting result does not change.
   `ITBS_ASSERT(a_rsp_payload_holds, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_found) && $stable(rsp_match_index), "rsp payload changed while stalled")

   // A miss or a load always reports index zero.
   `ITBS_ASSERT_NEVER(a_miss_index_zero, clock, reset, rsp_valid && !rsp_found && (rsp_match_index != MATCH_W'(0)), "nonzero index without a match")

   // Only one item is in work: the input stalls right after an acceptance.
   `ITBS_ASSERT(a_one_in_work, clock, reset, req_valid && !req_stall |=> req_stall, "second item accepted back to back")

endmodule

bind interval_table_binary_search_core itbs_checker u_itbs_checker (.*);
